@@ sv/ipe_pkg.sv @@
// ----------------------------------------------------------------------------
// ipe_pkg
// Shared types and constants of the inductor position estimator: register
// indexes and reset values, normalization caps, loss thresholds, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ipe_pkg;

	localparam int CFG_W      = 12;
	localparam int LIMIT_W    = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int NORM_W     = 8;
	localparam int OFFSET_W   = 9;

	localparam int SCALE          = 100;
	localparam int VERT_CAP       = 200;
	localparam int HORZ_CAP       = 100;
	localparam int LOSS_SUM_MAX   = 5;
	localparam int LOSS_COIL_MAX  = 2;
	localparam int LOSS_TOTAL_MAX = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LV_MIN     = 3'd0,
		REG_RV_MIN     = 3'd1,
		REG_LH_MIN     = 3'd2,
		REG_RH_MIN     = 3'd3,
		REG_VERT_FULL  = 3'd4,
		REG_HORZ_FULL  = 3'd5,
		REG_LOSS_LIMIT = 3'd6
	} reg_idx_t;

	localparam logic [CFG_W-1:0]   RST_LV_MIN     = 12'd25;
	localparam logic [CFG_W-1:0]   RST_RV_MIN     = 12'd1;
	localparam logic [CFG_W-1:0]   RST_LH_MIN     = 12'd35;
	localparam logic [CFG_W-1:0]   RST_RH_MIN     = 12'd15;
	localparam logic [CFG_W-1:0]   RST_VERT_FULL  = 12'd3600;
	localparam logic [CFG_W-1:0]   RST_HORZ_FULL  = 12'd2300;
	localparam logic [LIMIT_W-1:0] RST_LOSS_LIMIT = 16'd400;

	// coil order: left vertical, right vertical, left horizontal, right horizontal
	typedef struct packed {
		logic [3:0][CFG_W-1:0] mins;
		logic [CFG_W-1:0]      vert_full;
		logic [CFG_W-1:0]      horz_full;
		logic [LIMIT_W-1:0]    loss_limit;
	} ipe_cfg_t;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_START  = 7'b0000010,
		S_WAIT   = 7'b0000100,
		S_PREP   = 7'b0001000,
		S_PSTART = 7'b0010000,
		S_PWAIT  = 7'b0100000,
		S_FIN    = 7'b1000000
	} ipe_state_t;

endpackage

`default_nettype wire

@@ sv/ipe_cfg.sv @@
// ----------------------------------------------------------------------------
// ipe_cfg
// Configuration register file: coil offsets, full-scale readings and the
// loss limit, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ipe_cfg import ipe_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output ipe_cfg_t                   cfg
);

	ipe_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mins[0]    <= RST_LV_MIN;
			cfg_q.mins[1]    <= RST_RV_MIN;
			cfg_q.mins[2]    <= RST_LH_MIN;
			cfg_q.mins[3]    <= RST_RH_MIN;
			cfg_q.vert_full  <= RST_VERT_FULL;
			cfg_q.horz_full  <= RST_HORZ_FULL;
			cfg_q.loss_limit <= RST_LOSS_LIMIT;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_LV_MIN:     cfg_q.mins[0]    <= cfg_data[CFG_W-1:0];
				REG_RV_MIN:     cfg_q.mins[1]    <= cfg_data[CFG_W-1:0];
				REG_LH_MIN:     cfg_q.mins[2]    <= cfg_data[CFG_W-1:0];
				REG_RH_MIN:     cfg_q.mins[3]    <= cfg_data[CFG_W-1:0];
				REG_VERT_FULL:  cfg_q.vert_full  <= cfg_data[CFG_W-1:0];
				REG_HORZ_FULL:  cfg_q.horz_full  <= cfg_data[CFG_W-1:0];
				REG_LOSS_LIMIT: cfg_q.loss_limit <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ sv/ipe_div.sv @@
// ----------------------------------------------------------------------------
// ipe_div
// Serial restoring divider: one quotient bit per cycle, quotient valid while
// done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ipe_div #(
	parameter int NUM_W = 19,
	parameter int DEN_W = 12
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [NUM_W-1:0]      quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;

	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [DEN_W:0]   rem_sub;

	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

`default_nettype wire

@@ sv/inductor_position_estimator.sv @@
// ----------------------------------------------------------------------------
// Sequencing: five divisions in turn on one serial divider, one quotient bit
//   per cycle, NUMW bits wide (NUMW = max(SAMPLE_BITS+7, 16)); a new input
//   is not taken until the result is loaded into the output register, and
//   in_stall is high meanwhile.
// Reset: asynchronous, clears loss timer, held offset, stop flag and output
//   valid; configuration registers return to their default values.
// ----------------------------------------------------------------------------
// inductor_position_estimator
// Normalizes four coil readings, forms the weighted lateral offset and runs
// the lost-signal hold, beeper and sticky stop protection.
// ----------------------------------------------------------------------------
`default_nettype none

module inductor_position_estimator import ipe_pkg::*; #(
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [SAMPLE_BITS-1:0] left_vertical_sample,
	input  wire logic [SAMPLE_BITS-1:0] right_vertical_sample,
	input  wire logic [SAMPLE_BITS-1:0] left_horizontal_sample,
	input  wire logic [SAMPLE_BITS-1:0] right_horizontal_sample,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic signed [OFFSET_W-1:0]  track_offset,
	output logic                        beeper_on,
	output logic                        stop_request
);

	localparam int NUMW = (SAMPLE_BITS + 7 > 16) ? SAMPLE_BITS + 7 : 16;
	localparam int DENW = (SAMPLE_BITS > 9) ? SAMPLE_BITS : 9;
	localparam int PRODW = SAMPLE_BITS + 7;

	ipe_cfg_t cfg;

	ipe_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ipe_state_t state_q;

	logic [3:0][SAMPLE_BITS-1:0] samp_q;
	logic [1:0]                  k_q;
	logic [3:0][NORM_W-1:0]      norm_q;
	logic signed [10:0]          sum_q;
	logic [8:0]                  den_q;
	logic [NORM_W-1:0]           quo_q;

	logic [LIMIT_W-1:0]          loss_q;
	logic signed [OFFSET_W-1:0]  held_q;
	logic                        stop_q;

	logic                        out_valid_q;
	logic signed [OFFSET_W-1:0]  offset_q;
	logic                        beep_q;
	logic                        stopo_q;

	logic                        div_start;
	logic                        div_done;
	logic [NUMW-1:0]             div_num;
	logic [DENW-1:0]             div_den;
	logic [NUMW-1:0]             div_quo;

	ipe_div #(
		.NUM_W (NUMW),
		.DEN_W (DENW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	logic                   in_xfer;
	logic                   out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// normalization operands
	logic [SAMPLE_BITS-1:0] x_sel;
	logic [SAMPLE_BITS-1:0] lo_sel;
	logic [SAMPLE_BITS-1:0] full_sel;
	logic [SAMPLE_BITS-1:0] span;
	logic [SAMPLE_BITS-1:0] diff;
	logic [PRODW-1:0]       norm_prod;
	logic [NUMW-1:0]        cap_sel;
	logic [NUMW-1:0]        norm_clamped;

	assign x_sel    = samp_q[k_q];
	assign lo_sel   = SAMPLE_BITS'({{SAMPLE_BITS{1'b0}}, cfg.mins[k_q]});
	assign full_sel = k_q[1] ? SAMPLE_BITS'({{SAMPLE_BITS{1'b0}}, cfg.horz_full})
	                         : SAMPLE_BITS'({{SAMPLE_BITS{1'b0}}, cfg.vert_full});
	assign span     = (full_sel > lo_sel) ? full_sel - lo_sel : SAMPLE_BITS'(1);
	assign diff     = (x_sel > lo_sel) ? x_sel - lo_sel : '0;
	assign norm_prod = PRODW'(diff) * PRODW'(SCALE);
	assign cap_sel  = k_q[1] ? NUMW'(HORZ_CAP) : NUMW'(VERT_CAP);
	assign norm_clamped = (div_quo > cap_sel) ? cap_sel : div_quo;

	// position operands
	logic [NORM_W-1:0]  lv, rv, lh, rh;
	logic signed [10:0] dh, dv, adv, dsum;
	logic [8:0]         sh9, lvrv9;
	logic [9:0]         total10;
	logic [9:0]         pos_mag;
	logic [15:0]        pos_prod;

	assign lv = norm_q[0];
	assign rv = norm_q[1];
	assign lh = norm_q[2];
	assign rh = norm_q[3];

	assign dh      = $signed({3'b000, lh}) - $signed({3'b000, rh});
	assign dv      = $signed({3'b000, lv}) - $signed({3'b000, rv});
	assign adv     = dv[10] ? -dv : dv;
	assign dsum    = dh + (dv <<< 1);
	assign sh9     = 9'(lh) + 9'(rh);
	assign lvrv9   = 9'(lv) + 9'(rv);
	assign total10 = 10'(sh9) + 10'(lvrv9);
	assign pos_mag = 10'(sum_q[10] ? -sum_q : sum_q);
	assign pos_prod = 16'(pos_mag) * 16'(SCALE);

	always_comb begin
		div_start = (state_q == S_START) || (state_q == S_PSTART);
		if (state_q == S_PSTART) begin
			div_num = NUMW'(pos_prod);
			div_den = DENW'(den_q);
		end else begin
			div_num = NUMW'(norm_prod);
			div_den = DENW'(span);
		end
	end

	// lost-signal hold and stop protection
	logic signed [OFFSET_W-1:0] pos_v;
	logic                       enter;
	logic [LIMIT_W-1:0]         lt1, lt2;
	logic signed [OFFSET_W-1:0] held1, pos2, pos3;
	logic                       beep2, over;

	always_comb begin
		pos_v = sum_q[10] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		enter = (loss_q == '0) && (sh9 <= 9'(LOSS_SUM_MAX))
			&& ((lh <= NORM_W'(LOSS_COIL_MAX)) || (rh <= NORM_W'(LOSS_COIL_MAX)))
			&& ((lv <= NORM_W'(LOSS_COIL_MAX)) || (rv <= NORM_W'(LOSS_COIL_MAX)))
			&& (lvrv9 <= 9'(LOSS_SUM_MAX));
		lt1   = enter ? LIMIT_W'(1) : loss_q;
		held1 = enter ? pos_v : held_q;
		if ((lt1 != '0) && (total10 <= 10'(LOSS_TOTAL_MAX))) begin
			lt2   = lt1 + 1'b1;
			pos2  = held1;
			beep2 = 1'b1;
		end else begin
			lt2   = '0;
			pos2  = pos_v;
			beep2 = 1'b0;
		end
		over = lt2 > cfg.loss_limit;
		pos3 = over ? '0 : pos2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			loss_q      <= '0;
			held_q      <= '0;
			stop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						k_q     <= '0;
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_WAIT;
				S_WAIT: begin
					if (div_done) begin
						k_q     <= k_q + 1'b1;
						state_q <= (k_q == 2'd3) ? S_PREP : S_START;
					end
				end
				S_PREP:   state_q <= S_PSTART;
				S_PSTART: state_q <= S_PWAIT;
				S_PWAIT: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						loss_q      <= lt2;
						held_q      <= held1;
						stop_q      <= stop_q | over;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			samp_q[0] <= left_vertical_sample;
			samp_q[1] <= right_vertical_sample;
			samp_q[2] <= left_horizontal_sample;
			samp_q[3] <= right_horizontal_sample;
		end
		if ((state_q == S_WAIT) && div_done) begin
			norm_q[k_q] <= norm_clamped[NORM_W-1:0];
		end
		if (state_q == S_PREP) begin
			sum_q <= dsum;
			den_q <= 9'(sh9 + 9'(adv) + 9'd1);
		end
		if ((state_q == S_PWAIT) && div_done) begin
			quo_q <= div_quo[NORM_W-1:0];
		end
		if ((state_q == S_FIN) && out_free) begin
			offset_q <= pos3;
			beep_q   <= beep2 && !over;
			stopo_q  <= stop_q | over;
		end
	end

	assign out_valid    = out_valid_q;
	assign track_offset = offset_q;
	assign beeper_on    = beep_q;
	assign stop_request = stopo_q;

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input taken while a tick is in progress");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stop_request) |=> stop_request)
		else $error("stop request dropped");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (track_offset <= 9'sd200) && (track_offset >= -9'sd200))
		else $error("offset out of range");

	a_beep_no_stop_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && beeper_on) |-> (loss_q <= cfg.loss_limit))
		else $error("beeper on past the loss limit");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - inductor position estimator testbench
// Drives four coil readings per transfer under several register settings and
// pacing modes, predicts offset, beeper and stop flag per reading, and checks
// each result transfer in order against the prediction.
// ----------------------------------------------------------------------------

module tb;
	import ipe_pkg::*;

	localparam int SAMPLE_W = 12;
	localparam int LV = 0;
	localparam int RV = 1;
	localparam int LH = 2;
	localparam int RH = 3;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	typedef logic [3:0][SAMPLE_W-1:0] coil_set_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic                beep;
		logic                stop;
	} position_t;

	class offset_scoreboard;
		logic [CFG_W-1:0]    mins [4];
		logic [CFG_W-1:0]    vert_full;
		logic [CFG_W-1:0]    horz_full;
		logic [LIMIT_W-1:0]  loss_limit;
		logic [LIMIT_W-1:0]  loss_ticks;
		logic signed [OFFSET_W-1:0] held_offset;
		logic                stop_latch;
		position_t           expected_positions [$];
		int                  mismatches;

		function new();
			mins[LV] = RST_LV_MIN;
			mins[RV] = RST_RV_MIN;
			mins[LH] = RST_LH_MIN;
			mins[RH] = RST_RH_MIN;
			vert_full = RST_VERT_FULL;
			horz_full = RST_HORZ_FULL;
			loss_limit = RST_LOSS_LIMIT;
			loss_ticks = '0;
			held_offset = '0;
			stop_latch = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_LV_MIN:     mins[LV] = data[CFG_W-1:0];
				REG_RV_MIN:     mins[RV] = data[CFG_W-1:0];
				REG_LH_MIN:     mins[LH] = data[CFG_W-1:0];
				REG_RH_MIN:     mins[RH] = data[CFG_W-1:0];
				REG_VERT_FULL:  vert_full = data[CFG_W-1:0];
				REG_HORZ_FULL:  horz_full = data[CFG_W-1:0];
				REG_LOSS_LIMIT: loss_limit = data[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function int coil_percent(int x, int lo, int full, int cap);
			int span;
			int q;
			span = full - lo;
			if (span < 1)
				span = 1;
			if (x <= lo)
				return 0;
			q = ((x - lo) * SCALE) / span;
			return (q > cap) ? cap : q;
		endfunction

		function void note_reading(coil_set_t s);
			int lv, rv, lh, rh, dh, dv, sh, adv, pos;
			position_t r;
			lv = coil_percent(s[LV], mins[LV], vert_full, VERT_CAP);
			rv = coil_percent(s[RV], mins[RV], vert_full, VERT_CAP);
			lh = coil_percent(s[LH], mins[LH], horz_full, HORZ_CAP);
			rh = coil_percent(s[RH], mins[RH], horz_full, HORZ_CAP);
			dh = lh - rh;
			dv = lv - rv;
			sh = lh + rh;
			adv = (dv < 0) ? -dv : dv;
			pos = ((dh + 2 * dv) * SCALE) / (sh + adv + 1);
			r.beep = 1'b0;
			if (loss_ticks == 0 && sh <= LOSS_SUM_MAX &&
					(lh <= LOSS_COIL_MAX || rh <= LOSS_COIL_MAX) &&
					(lv <= LOSS_COIL_MAX || rv <= LOSS_COIL_MAX) &&
					(lv + rv) <= LOSS_SUM_MAX) begin
				held_offset = OFFSET_W'(pos);
				loss_ticks = loss_ticks + 1'b1;
			end
			if (loss_ticks != 0 && (lv + rv + lh + rh) <= LOSS_TOTAL_MAX) begin
				loss_ticks = loss_ticks + 1'b1;
				pos = held_offset;
				r.beep = 1'b1;
			end else begin
				loss_ticks = '0;
			end
			if (loss_ticks > loss_limit) begin
				stop_latch = 1'b1;
				pos = 0;
				r.beep = 1'b0;
			end
			r.offset = pos[OFFSET_W-1:0];
			r.stop = stop_latch;
			expected_positions.push_back(r);
		endfunction

		function void check_result(logic [OFFSET_W-1:0] offset, logic beep, logic stop);
			position_t e;
			if (expected_positions.size() == 0) begin
				$display("%0t: unexpected result: track_offset %0d beeper_on %0b stop_request %0b",
					$time, $signed(offset), beep, stop);
				mismatches++;
				return;
			end
			e = expected_positions.pop_front();
			if (offset !== e.offset) begin
				$display("%0t: track_offset expected %0d actual %0d",
					$time, $signed(e.offset), $signed(offset));
				mismatches++;
			end
			if (beep !== e.beep) begin
				$display("%0t: beeper_on expected %0b actual %0b", $time, e.beep, beep);
				mismatches++;
			end
			if (stop !== e.stop) begin
				$display("%0t: stop_request expected %0b actual %0b", $time, e.stop, stop);
				mismatches++;
			end
		endfunction

		function int pending_count();
			return expected_positions.size();
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_write;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_DATA_W-1:0]       cfg_data;
	logic                        in_valid;
	logic                        in_stall;
	logic [SAMPLE_W-1:0]         left_vertical_sample;
	logic [SAMPLE_W-1:0]         right_vertical_sample;
	logic [SAMPLE_W-1:0]         left_horizontal_sample;
	logic [SAMPLE_W-1:0]         right_horizontal_sample;
	logic                        out_valid;
	logic                        out_stall;
	logic signed [OFFSET_W-1:0]  track_offset;
	logic                        beeper_on;
	logic                        stop_request;

	offset_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;

	inductor_position_estimator #(.SAMPLE_BITS(SAMPLE_W)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.left_vertical_sample(left_vertical_sample),
		.right_vertical_sample(right_vertical_sample),
		.left_horizontal_sample(left_horizontal_sample),
		.right_horizontal_sample(right_horizontal_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.track_offset(track_offset),
		.beeper_on(beeper_on),
		.stop_request(stop_request)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#15_000_000;
		$display("Mismatches found");
		$finish;
	end

	// result side: hold off on request, else stall at random
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(track_offset, beeper_on, stop_request);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	function automatic logic [SAMPLE_W-1:0] coil_sample(int c, int pct);
		int lo, full, span, x;
		lo = sb.mins[c];
		full = (c < LH) ? sb.vert_full : sb.horz_full;
		span = full - lo;
		if (span < 1)
			span = 1;
		if (pct == 0)
			x = $urandom_range(lo);
		else
			x = lo + (span * pct + SCALE - 1) / SCALE;
		if (x > (1 << SAMPLE_W) - 1)
			x = (1 << SAMPLE_W) - 1;
		return x[SAMPLE_W-1:0];
	endfunction

	function automatic logic [CFG_DATA_W-1:0] with_junk(int v);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom_range(16'hFFFF));
		d[CFG_W-1:0] = v[CFG_W-1:0];
		return d;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic configure(input int lvm, input int rvm, input int lhm, input int rhm,
			input int vfull, input int hfull, input int limit);
		write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom_range(16'hFFFF)));
		write_reg(REG_LV_MIN, with_junk(lvm));
		write_reg(REG_RV_MIN, with_junk(rvm));
		write_reg(REG_LH_MIN, with_junk(lhm));
		write_reg(REG_RH_MIN, with_junk(rhm));
		write_reg(REG_VERT_FULL, with_junk(vfull));
		write_reg(REG_HORZ_FULL, with_junk(hfull));
		write_reg(REG_LOSS_LIMIT, limit[CFG_DATA_W-1:0]);
		cfg_write <= 1'b0;
	endtask

	task automatic send_reading(input coil_set_t s);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		left_vertical_sample <= s[LV];
		right_vertical_sample <= s[RV];
		left_horizontal_sample <= s[LH];
		right_horizontal_sample <= s[RH];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_reading(s);
	endtask

	task automatic send4(input int lv, input int rv, input int lh, input int rh);
		coil_set_t s;
		s[LV] = lv[SAMPLE_W-1:0];
		s[RV] = rv[SAMPLE_W-1:0];
		s[LH] = lh[SAMPLE_W-1:0];
		s[RH] = rh[SAMPLE_W-1:0];
		send_reading(s);
	endtask

	task automatic send_pct(input int lv, input int rv, input int lh, input int rh);
		send4(coil_sample(LV, lv), coil_sample(RV, rv), coil_sample(LH, lh), coil_sample(RH, rh));
	endtask

	task automatic send_quiet(input bit entry);
		coil_set_t s;
		for (int c = 0; c < 4; c++)
			s[c] = coil_sample(c, $urandom_range(entry ? LOSS_COIL_MAX + (c % 2) : 6));
		send_reading(s);
	endtask

	task automatic send_mixed();
		coil_set_t s;
		int r;
		for (int c = 0; c < 4; c++) begin
			r = $urandom_range(99);
			if (r < 50)
				s[c] = SAMPLE_W'($urandom_range((1 << SAMPLE_W) - 1));
			else if (r < 80)
				s[c] = coil_sample(c, $urandom_range(((c < LH) ? VERT_CAP : HORZ_CAP) + 20));
			else
				s[c] = coil_sample(c, $urandom_range(5));
		end
		send_reading(s);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
	endtask

	// mostly loss episodes and recoveries, the rest unconstrained readings
	task automatic run_phase(input int count, input int send_pct, input int stall_pct);
		int sent;
		int len;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 40) begin
				len = $urandom_range(30, 1);
				if (len > count - sent)
					len = count - sent;
				send_quiet(1'b1);
				for (int i = 1; i < len; i++)
					send_quiet(1'b0);
				sent += len;
			end else begin
				send_mixed();
				sent++;
			end
		end
		drain();
	endtask

	initial begin
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		arst_n = 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		left_vertical_sample <= '0;
		right_vertical_sample <= '0;
		left_horizontal_sample <= '0;
		right_horizontal_sample <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send4(0, 0, 0, 0);
		send4(0, 0, 0, 0);
		send_pct(5, 5, 4, 4);
		send4(4095, 4095, 4095, 4095);
		send4(4095, 0, 0, 0);
		send4(0, 4095, 0, 0);
		send4(0, 0, 4095, 0);
		send4(0, 0, 0, 4095);
		send4(4095, 0, 4095, 0);
		send4(0, 4095, 0, 4095);
		send4(12'hAAA, 12'h555, 12'hAAA, 12'h555);
		send4(12'h555, 12'hAAA, 12'h555, 12'hAAA);
		send4(RST_LV_MIN - 1, 0, RST_LH_MIN - 1, RST_RH_MIN - 1);
		send_pct(6, 5, 5, 5);
		send4(RST_LV_MIN, RST_RV_MIN, RST_LH_MIN, RST_RH_MIN);
		send4(RST_LV_MIN + 1, RST_RV_MIN + 1, RST_LH_MIN + 1, RST_RH_MIN + 1);
		send_pct(2, 0, 2, 0);
		send4(0, 0, 0, 0);
		send_pct(5, 5, 5, 5);
		send_pct(6, 5, 5, 5);
		send_pct(1, 1, 1, 1);
		send_pct(3, 0, 0, 0);
		drain();

		configure($urandom_range(400), $urandom_range(400), $urandom_range(400),
			$urandom_range(400), $urandom_range(4095, 3000), $urandom_range(4095, 1500), 16'hFFFF);
		run_phase(110, 87, 0);

		configure(0, 0, 0, 0, 4095, 4095, 400);
		hold_left = 2500;
		run_phase(110, 0, 87);

		// spans of one and below: full at or under the minimum
		configure(4095, 0, 3000, 2000, 0, 2000, 1000);
		run_phase(110, 34, 34);

		configure($urandom_range(500), $urandom_range(500), $urandom_range(500),
			$urandom_range(500), $urandom_range(4095, 2000), $urandom_range(4095, 2000), 12);
		run_phase(110, 0, 0);

		configure($urandom_range(1000), $urandom_range(1000), $urandom_range(1000),
			$urandom_range(1000), $urandom_range(4095), $urandom_range(4095), 0);
		run_phase(110, 34, 34);

		repeat (150) @(posedge clk);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
